>>> rtl/core/dmfp_pkg.sv
// shared types and constants of the dns message field parser
// no dependencies; used by the front, queue, back and top modules
`default_nettype none

package dmfp_pkg;

   // field kind codes on the result channel
   localparam logic [4:0] KIND_ID        = 5'd0;
   localparam logic [4:0] KIND_QR        = 5'd1;
   localparam logic [4:0] KIND_OPCODE    = 5'd2;
   localparam logic [4:0] KIND_AA        = 5'd3;
   localparam logic [4:0] KIND_TC        = 5'd4;
   localparam logic [4:0] KIND_RD        = 5'd5;
   localparam logic [4:0] KIND_RA        = 5'd6;
   localparam logic [4:0] KIND_Z         = 5'd7;
   localparam logic [4:0] KIND_RCODE     = 5'd8;
   localparam logic [4:0] KIND_QDCOUNT   = 5'd9;
   localparam logic [4:0] KIND_ANCOUNT   = 5'd10;
   localparam logic [4:0] KIND_NSCOUNT   = 5'd11;
   localparam logic [4:0] KIND_ARCOUNT   = 5'd12;
   localparam logic [4:0] KIND_NAME_CHAR = 5'd13;
   localparam logic [4:0] KIND_QTYPE     = 5'd14;
   localparam logic [4:0] KIND_QCLASS    = 5'd15;
   localparam logic [4:0] KIND_ANAME     = 5'd16;
   localparam logic [4:0] KIND_ATYPE     = 5'd17;
   localparam logic [4:0] KIND_ACLASS    = 5'd18;
   localparam logic [4:0] KIND_TTL       = 5'd19;
   localparam logic [4:0] KIND_RDLENGTH  = 5'd20;
   localparam logic [4:0] KIND_RDATA     = 5'd21;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // how the back end expands one queued entry
   typedef enum logic [1:0] {
      OP_SINGLE,
      OP_FLAGS1,
      OP_FLAGS2
   } op_type;

   localparam logic [2:0] FLAGS1_LAST_SUB = 3'd4;
   localparam logic [2:0] FLAGS2_LAST_SUB = 3'd2;

   typedef struct packed {
      op_type      op;
      logic [4:0]  kind;
      logic [31:0] value;
      logic        done;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/core/dmfp_front.sv
// front end: per-byte parse state machine that classifies each byte
// into at most one queue entry; depends on dmfp_pkg
`default_nettype none

module dmfp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         data_byte,
   input  wire logic               start_of_message,
   output logic                    entry_valid,
   output dmfp_pkg::entry_type     entry
);

   typedef enum logic [4:0] {
      PH_ID      = 5'd0,
      PH_FLAGS1  = 5'd1,
      PH_FLAGS2  = 5'd2,
      PH_QDCOUNT = 5'd3,
      PH_ANCOUNT = 5'd4,
      PH_NSCOUNT = 5'd5,
      PH_ARCOUNT = 5'd6,
      PH_QNAME   = 5'd7,
      PH_QTYPE   = 5'd8,
      PH_QCLASS  = 5'd9,
      PH_ANAME   = 5'd10,
      PH_ATYPE   = 5'd11,
      PH_ACLASS  = 5'd12,
      PH_TTL     = 5'd13,
      PH_RDLEN   = 5'd14,
      PH_RDATA   = 5'd15,
      PH_DONE    = 5'd16
   } phase_type;

   phase_type   phase_ff, phase_in, ph;
   logic [1:0]  idx_ff, idx_in, idx;
   logic [23:0] part_ff, part_in, part;
   logic [7:0]  label_ff, label_in, label;
   logic        dot_ff, dot_in, dot;
   logic [15:0] ancount_ff, ancount_in, ancount;
   logic [15:0] rdrem_ff, rdrem_in, rdrem;

   logic [31:0] acc;
   logic [2:0]  need;
   logic        complete;
   logic        multi;
   logic [15:0] rdrem_dec;

   always_comb begin
      // a start byte sees the reset state
      ph      = start_of_message ? PH_ID : phase_ff;
      idx     = start_of_message ? 2'd0 : idx_ff;
      part    = start_of_message ? 24'd0 : part_ff;
      label   = start_of_message ? 8'd0 : label_ff;
      dot     = start_of_message ? 1'b0 : dot_ff;
      ancount = start_of_message ? 16'd0 : ancount_ff;
      rdrem   = start_of_message ? 16'd0 : rdrem_ff;

      acc       = {part, data_byte};
      need      = (ph == PH_TTL) ? 3'd4 : 3'd2;
      complete  = ({1'b0, idx} + 3'd1) >= need;
      rdrem_dec = rdrem - 16'd1;

      phase_in   = ph;
      idx_in     = idx;
      part_in    = part;
      label_in   = label;
      dot_in     = dot;
      ancount_in = ancount;
      rdrem_in   = rdrem;

      entry_valid = 1'b0;
      entry.op    = dmfp_pkg::OP_SINGLE;
      entry.kind  = dmfp_pkg::KIND_ID;
      entry.value = acc;
      entry.done  = 1'b0;

      case (ph)
         PH_ID, PH_QDCOUNT, PH_ANCOUNT, PH_NSCOUNT, PH_ARCOUNT, PH_QTYPE,
         PH_QCLASS, PH_ANAME, PH_ATYPE, PH_ACLASS, PH_TTL, PH_RDLEN: multi = 1'b1;
         default: multi = 1'b0;
      endcase

      // big-endian accumulation of multi-byte fields
      if (multi) begin
         if (complete) begin
            idx_in  = 2'd0;
            part_in = 24'd0;
         end else begin
            idx_in  = idx + 2'd1;
            part_in = acc[23:0];
         end
      end

      case (ph)
         PH_ID: begin
            entry.kind = dmfp_pkg::KIND_ID;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_FLAGS1;
            end
         end
         PH_FLAGS1: begin
            entry_valid = 1'b1;
            entry.op    = dmfp_pkg::OP_FLAGS1;
            entry.kind  = dmfp_pkg::KIND_QR;
            phase_in    = PH_FLAGS2;
         end
         PH_FLAGS2: begin
            entry_valid = 1'b1;
            entry.op    = dmfp_pkg::OP_FLAGS2;
            entry.kind  = dmfp_pkg::KIND_RA;
            phase_in    = PH_QDCOUNT;
         end
         PH_QDCOUNT: begin
            entry.kind = dmfp_pkg::KIND_QDCOUNT;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_ANCOUNT;
            end
         end
         PH_ANCOUNT: begin
            entry.kind = dmfp_pkg::KIND_ANCOUNT;
            if (complete) begin
               entry_valid = 1'b1;
               ancount_in  = acc[15:0];
               phase_in    = PH_NSCOUNT;
            end
         end
         PH_NSCOUNT: begin
            entry.kind = dmfp_pkg::KIND_NSCOUNT;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_ARCOUNT;
            end
         end
         PH_ARCOUNT: begin
            entry.kind = dmfp_pkg::KIND_ARCOUNT;
            if (complete) begin
               entry_valid = 1'b1;
               label_in    = 8'd0;
               dot_in      = 1'b0;
               phase_in    = PH_QNAME;
            end
         end
         PH_QNAME: begin
            entry.kind = dmfp_pkg::KIND_NAME_CHAR;
            if (label == 8'd0) begin
               if (data_byte == 8'd0) begin
                  // end of name, no result
                  dot_in   = 1'b0;
                  phase_in = PH_QTYPE;
               end else begin
                  label_in = data_byte;
                  if (dot) begin
                     entry_valid = 1'b1;
                     entry.value = {24'd0, dmfp_pkg::DOT_CHAR};
                     dot_in      = 1'b0;
                  end
               end
            end else begin
               entry_valid = 1'b1;
               entry.value = {24'd0, data_byte};
               dot_in      = 1'b1;
               label_in    = label - 8'd1;
            end
         end
         PH_QTYPE: begin
            entry.kind = dmfp_pkg::KIND_QTYPE;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_QCLASS;
            end
         end
         PH_QCLASS: begin
            entry.kind = dmfp_pkg::KIND_QCLASS;
            entry.done = (ancount == 16'd0);
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = (ancount == 16'd0) ? PH_DONE : PH_ANAME;
            end
         end
         PH_ANAME: begin
            entry.kind = dmfp_pkg::KIND_ANAME;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_ATYPE;
            end
         end
         PH_ATYPE: begin
            entry.kind = dmfp_pkg::KIND_ATYPE;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_ACLASS;
            end
         end
         PH_ACLASS: begin
            entry.kind = dmfp_pkg::KIND_ACLASS;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_TTL;
            end
         end
         PH_TTL: begin
            entry.kind = dmfp_pkg::KIND_TTL;
            if (complete) begin
               entry_valid = 1'b1;
               phase_in    = PH_RDLEN;
            end
         end
         PH_RDLEN: begin
            entry.kind = dmfp_pkg::KIND_RDLENGTH;
            entry.done = (acc[15:0] == 16'd0);
            if (complete) begin
               entry_valid = 1'b1;
               rdrem_in    = acc[15:0];
               phase_in    = (acc[15:0] == 16'd0) ? PH_DONE : PH_RDATA;
            end
         end
         PH_RDATA: begin
            entry_valid = 1'b1;
            entry.kind  = dmfp_pkg::KIND_RDATA;
            entry.value = {24'd0, data_byte};
            entry.done  = (rdrem_dec == 16'd0);
            rdrem_in    = rdrem_dec;
            if (rdrem_dec == 16'd0) begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ID;
         idx_ff     <= 2'd0;
         part_ff    <= 24'd0;
         label_ff   <= 8'd0;
         dot_ff     <= 1'b0;
         ancount_ff <= 16'd0;
         rdrem_ff   <= 16'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         part_ff    <= part_in;
         label_ff   <= label_in;
         dot_ff     <= dot_in;
         ancount_ff <= ancount_in;
         rdrem_ff   <= rdrem_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dmfp_queue.sv
// short entry queue between the front and back ends
// depends on dmfp_pkg for the entry type
`default_nettype none

module dmfp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire dmfp_pkg::entry_type wr_entry,
   output logic                     full,
   input  wire logic                rd_en,
   output dmfp_pkg::entry_type      rd_entry,
   output logic                     not_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   dmfp_pkg::entry_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign rd_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? ((wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? ((rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dmfp_back.sv
// back end: expands queued entries into results, one per cycle into the
// output register while it is empty or popped; depends on dmfp_pkg
`default_nettype none

module dmfp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire dmfp_pkg::entry_type q_entry,
   output logic                     q_pop,
   output logic                     out_valid,
   input  wire logic                out_pop,
   output logic [4:0]               out_kind,
   output logic [31:0]              out_value,
   output logic                     out_run_end,
   output logic                     out_done
);

   logic        valid_ff, valid_in;
   logic [2:0]  sub_ff, sub_in;
   logic [4:0]  kind_ff, kind_in;
   logic [31:0] value_ff, value_in;
   logic        run_end_ff;
   logic        done_ff;
   logic        load;
   logic        last;
   logic [2:0]  last_sub;
   logic [7:0]  fb;

   always_comb begin
      fb = q_entry.value[7:0];
      case (q_entry.op)
         dmfp_pkg::OP_FLAGS1: last_sub = dmfp_pkg::FLAGS1_LAST_SUB;
         dmfp_pkg::OP_FLAGS2: last_sub = dmfp_pkg::FLAGS2_LAST_SUB;
         default:             last_sub = 3'd0;
      endcase
      last = (sub_ff == last_sub);
      load = q_valid && (!valid_ff || out_pop);

      kind_in  = q_entry.kind;
      value_in = q_entry.value;
      case (q_entry.op)
         dmfp_pkg::OP_FLAGS1: begin
            case (sub_ff)
               3'd0: begin
                  kind_in  = dmfp_pkg::KIND_QR;
                  value_in = {31'd0, fb[7]};
               end
               3'd1: begin
                  kind_in  = dmfp_pkg::KIND_OPCODE;
                  value_in = {28'd0, fb[6:3]};
               end
               3'd2: begin
                  kind_in  = dmfp_pkg::KIND_AA;
                  value_in = {31'd0, fb[2]};
               end
               3'd3: begin
                  kind_in  = dmfp_pkg::KIND_TC;
                  value_in = {31'd0, fb[1]};
               end
               default: begin
                  kind_in  = dmfp_pkg::KIND_RD;
                  value_in = {31'd0, fb[0]};
               end
            endcase
         end
         dmfp_pkg::OP_FLAGS2: begin
            case (sub_ff)
               3'd0: begin
                  kind_in  = dmfp_pkg::KIND_RA;
                  value_in = {31'd0, fb[7]};
               end
               3'd1: begin
                  kind_in  = dmfp_pkg::KIND_Z;
                  value_in = {29'd0, fb[6:4]};
               end
               default: begin
                  kind_in  = dmfp_pkg::KIND_RCODE;
                  value_in = {28'd0, fb[3:0]};
               end
            endcase
         end
         default: begin
            kind_in  = q_entry.kind;
            value_in = q_entry.value;
         end
      endcase

      if (load) begin
         valid_in = 1'b1;
         sub_in   = last ? 3'd0 : sub_ff + 3'd1;
      end else begin
         valid_in = valid_ff && !out_pop;
         sub_in   = sub_ff;
      end
   end

   assign q_pop       = load && last;
   assign out_valid   = valid_ff;
   assign out_kind    = kind_ff;
   assign out_value   = value_ff;
   assign out_run_end = run_end_ff;
   assign out_done    = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         value_ff   <= value_in;
         run_end_ff <= last;
         done_ff    <= q_entry.done && last;
      end
   end

   // sub-result counter stays within the widest expansion
   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff <= dmfp_pkg::FLAGS1_LAST_SUB)
      else $error("sub-result counter out of range");

   // a partly expanded entry keeps its queue slot
   a_sub_holds_entry: assert property (@(posedge clock) disable iff (reset)
      (sub_ff != 3'd0) |-> q_valid)
      else $error("partly expanded entry left the queue");

   // a waiting result is never dropped without a pop
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_pop) |=> valid_ff)
      else $error("result dropped without pop");

   // the queue is popped only on the final result of an entry
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (valid_ff && run_end_ff))
      else $error("queue popped before last result");

endmodule

`default_nettype wire

>>> rtl/core/dns_message_field_parser_core.sv
// top level of the dns message field parser: front parser, entry queue
// and result expander; depends on dmfp_pkg, dmfp_front, dmfp_queue, dmfp_back
//
// usage
//  - request side is a queue: drive req_data_byte and req_start_of_message
//    with req_push; an item is taken on a clock edge with req_push high and
//    req_full low. req_start_of_message restarts the parse on that byte
//  - result side is a queue: while rsp_empty is low the oldest result sits
//    on rsp_field_kind, rsp_field_value, rsp_run_end and rsp_message_done;
//    it is taken on an edge with rsp_pop high
//  - the front parser takes one byte per cycle while req_full is low and
//    turns it into at most one queue entry; the back end expands an entry
//    into one to five results, one result per cycle into the output register
//    while that register is empty or popped. A byte's entry is written to the
//    entry queue as the byte is taken and is then loaded into the output register
//  - throughput: one byte per cycle, bounded by the result side at one
//    result per cycle; the first flags byte gives five results and the
//    second three
//  - a stalled receiver holds the output register; the entry queue
//    (QUEUE_DEPTH entries) fills and then raises req_full
//  - reset returns the parser to the id phase and empties the queue and
//    output register
`default_nettype none

module dns_message_field_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_message,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [4:0]       rsp_field_kind,
   output logic [31:0]      rsp_field_value,
   output logic             rsp_run_end,
   output logic             rsp_message_done
);

   logic                req_accept;
   logic                entry_valid;
   dmfp_pkg::entry_type entry;
   logic                q_full;
   logic                q_pop;
   logic                q_not_empty;
   dmfp_pkg::entry_type q_entry;
   logic                out_valid;

   assign req_full   = q_full;
   assign req_accept = req_push && !q_full;
   assign rsp_empty  = !out_valid;

   // byte classification and parse state
   dmfp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .data_byte        (req_data_byte),
      .start_of_message (req_start_of_message),
      .entry_valid      (entry_valid),
      .entry            (entry)
   );

   // decouples the parser from a stalled or busy back end
   dmfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_accept && entry_valid),
      .wr_entry  (entry),
      .full      (q_full),
      .rd_en     (q_pop),
      .rd_entry  (q_entry),
      .not_empty (q_not_empty)
   );

   // result expansion and output register
   dmfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_not_empty),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .out_valid   (out_valid),
      .out_pop     (rsp_pop),
      .out_kind    (rsp_field_kind),
      .out_value   (rsp_field_value),
      .out_run_end (rsp_run_end),
      .out_done    (rsp_message_done)
   );

endmodule

`default_nettype wire

>>> test/tb_dns_message_field_parser_core.sv
// self-checking testbench for dns_message_field_parser_core: directed bytes, then random
// messages under varied handshake idling; depends on dmfp_pkg and the core rtl
`default_nettype none

module tb_dns_message_field_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_CYCLES    = 200;   // long receiver hold-off
   localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no item moving
   localparam int unsigned DRAIN_CYCLES   = 20;    // settle time after the last result
   localparam int unsigned NUM_DIRECTED   = 36;

   // parse position of the byte stream, kept by the predictor
   typedef enum logic [4:0] {
      ST_ID, ST_FLAGS1, ST_FLAGS2, ST_QDCOUNT, ST_ANCOUNT, ST_NSCOUNT, ST_ARCOUNT,
      ST_QNAME, ST_QTYPE, ST_QCLASS, ST_ANAME, ST_ATYPE, ST_ACLASS, ST_TTL,
      ST_RDLEN, ST_RDATA, ST_DONE
   } parse_phase_type;

   // one result item
   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic        run_end;
      logic        done;
   } dns_field_type;

   // directed stimulus row; kind/value/done only mean something when typed is set
   typedef struct packed {
      logic [7:0]  data;
      logic        som;
      logic        typed;
      logic [4:0]  kind;
      logic [31:0] value;
      logic        done;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_of_message = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [4:0]  rsp_field_kind;
   logic [31:0] rsp_field_value;
   logic        rsp_run_end;
   logic        rsp_message_done;

   // handshake shaping, set per phase by the stimulus process
   int unsigned send_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   logic        hold_request  = 1'b0;

   // predictor state
   parse_phase_type phase;
   logic [1:0]   byte_idx;
   logic [23:0]  partial;
   logic [7:0]   label_left;
   logic         dot_due;
   logic [15:0]  an_count;
   logic [15:0]  rdata_left;

   dns_field_type step_fields[$];      // results of the byte just taken
   dns_field_type expected_fields[$];  // results still to come out of the block

   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned results_checked = 0;
   int unsigned messages_done = 0;
   int unsigned messages_sent = 0;

   // directed bytes: restart mid id, flag extremes, odd counts, a name with a zero
   // character and a dot, an answer with a single rdata byte, then a stray byte
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'h5A, 1'b1, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},  // abandoned id
      '{8'h00, 1'b1, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},  // restart
      '{8'hFF, 1'b0, 1'b1, dmfp_pkg::KIND_ID,        32'h0000_00FF, 1'b0},
      '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},  // flags, all ones
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},  // flags, all zeros
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h00, 1'b0, 1'b1, dmfp_pkg::KIND_QDCOUNT,   32'h0,        1'b0},  // parsed anyway
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h02, 1'b0, 1'b1, dmfp_pkg::KIND_ANCOUNT,   32'h2,        1'b0},  // one answer only
      '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'hFF, 1'b0, 1'b1, dmfp_pkg::KIND_NSCOUNT,   32'hFFFF,     1'b0},
      '{8'h80, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h01, 1'b0, 1'b1, dmfp_pkg::KIND_ARCOUNT,   32'h8001,     1'b0},
      '{8'h01, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},  // first label length
      '{8'h00, 1'b0, 1'b1, dmfp_pkg::KIND_NAME_CHAR, 32'h0,        1'b0},  // zero in a label
      '{8'h01, 1'b0, 1'b1, dmfp_pkg::KIND_NAME_CHAR, {24'h0, dmfp_pkg::DOT_CHAR}, 1'b0},
      '{8'hFF, 1'b0, 1'b1, dmfp_pkg::KIND_NAME_CHAR, 32'hFF,       1'b0},
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},  // name end, silent
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h01, 1'b0, 1'b1, dmfp_pkg::KIND_QTYPE,     32'h1,        1'b0},
      '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'hFF, 1'b0, 1'b1, dmfp_pkg::KIND_QCLASS,    32'hFFFF,     1'b0},
      '{8'hC0, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h0C, 1'b0, 1'b1, dmfp_pkg::KIND_ANAME,     32'hC00C,     1'b0},
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h10, 1'b0, 1'b1, dmfp_pkg::KIND_ATYPE,     32'h10,       1'b0},
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h01, 1'b0, 1'b1, dmfp_pkg::KIND_ACLASS,    32'h1,        1'b0},
      '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'hFF, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'hFF, 1'b0, 1'b1, dmfp_pkg::KIND_TTL,       32'hFFFF_FFFF, 1'b0},
      '{8'h00, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0},
      '{8'h01, 1'b0, 1'b1, dmfp_pkg::KIND_RDLENGTH,  32'h1,        1'b0},
      '{8'h00, 1'b0, 1'b1, dmfp_pkg::KIND_RDATA,     32'h0,        1'b1},  // last field
      '{8'h77, 1'b0, 1'b0, dmfp_pkg::KIND_ID,        32'h0,        1'b0}   // after the message
   };

   dns_message_field_parser_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_data_byte        (req_data_byte),
      .req_start_of_message (req_start_of_message),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_field_kind       (rsp_field_kind),
      .rsp_field_value      (rsp_field_value),
      .rsp_run_end          (rsp_run_end),
      .rsp_message_done     (rsp_message_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   function void restart_parse();
      phase      = ST_ID;
      byte_idx   = '0;
      partial    = '0;
      label_left = '0;
      dot_due    = 1'b0;
      an_count   = '0;
      rdata_left = '0;
   endfunction

   // collect one big-endian byte; true once the field of width_bytes is whole
   function bit field_complete(input logic [7:0] b, input int unsigned width_bytes,
                               output logic [31:0] word);
      logic [31:0] acc;
      acc = {partial, b};
      word = acc;
      if (byte_idx + 1 >= width_bytes) begin
         partial  = '0;
         byte_idx = '0;
         return 1'b1;
      end
      partial  = acc[23:0];
      byte_idx = byte_idx + 2'd1;
      return 1'b0;
   endfunction

   function void add_field(input logic [4:0] kind, input logic [31:0] value,
                           input logic done);
      if (step_fields.size() < 5)
         step_fields.push_back('{kind, value, 1'b0, done});
   endfunction

   // advance the predicted parse by one byte, results land in step_fields
   function void parse_byte(input logic [7:0] b, input logic som);
      logic [31:0]   word;
      dns_field_type last;
      step_fields.delete();
      if (som)
         restart_parse();
      case (phase)
         ST_ID: begin
            if (field_complete(b, 2, word)) begin
               add_field(dmfp_pkg::KIND_ID, word, 1'b0);
               phase = ST_FLAGS1;
            end
         end
         ST_FLAGS1: begin
            add_field(dmfp_pkg::KIND_QR,     32'(b[7]),   1'b0);
            add_field(dmfp_pkg::KIND_OPCODE, 32'(b[6:3]), 1'b0);
            add_field(dmfp_pkg::KIND_AA,     32'(b[2]),   1'b0);
            add_field(dmfp_pkg::KIND_TC,     32'(b[1]),   1'b0);
            add_field(dmfp_pkg::KIND_RD,     32'(b[0]),   1'b0);
            phase = ST_FLAGS2;
         end
         ST_FLAGS2: begin
            add_field(dmfp_pkg::KIND_RA,    32'(b[7]),   1'b0);
            add_field(dmfp_pkg::KIND_Z,     32'(b[6:4]), 1'b0);
            add_field(dmfp_pkg::KIND_RCODE, 32'(b[3:0]), 1'b0);
            phase = ST_QDCOUNT;
         end
         ST_QDCOUNT, ST_ANCOUNT, ST_NSCOUNT, ST_ARCOUNT: begin
            if (field_complete(b, 2, word)) begin
               add_field(dmfp_pkg::KIND_QDCOUNT + 5'(phase - ST_QDCOUNT), word, 1'b0);
               if (phase == ST_ANCOUNT)
                  an_count = word[15:0];
               phase = parse_phase_type'(phase + 5'd1);
               if (phase == ST_QNAME) begin
                  label_left = '0;
                  dot_due    = 1'b0;
               end
            end
         end
         ST_QNAME: begin
            if (label_left == 0) begin
               // length byte: zero ends the name, anything else is a plain length
               if (b == 8'h00) begin
                  dot_due = 1'b0;
                  phase   = ST_QTYPE;
               end else begin
                  label_left = b;
                  if (dot_due) begin
                     add_field(dmfp_pkg::KIND_NAME_CHAR, {24'h0, dmfp_pkg::DOT_CHAR}, 1'b0);
                     dot_due = 1'b0;
                  end
               end
            end else begin
               add_field(dmfp_pkg::KIND_NAME_CHAR, 32'(b), 1'b0);
               dot_due    = 1'b1;
               label_left = label_left - 8'd1;
            end
         end
         ST_QTYPE: begin
            if (field_complete(b, 2, word)) begin
               add_field(dmfp_pkg::KIND_QTYPE, word, 1'b0);
               phase = ST_QCLASS;
            end
         end
         ST_QCLASS: begin
            if (field_complete(b, 2, word)) begin
               // no answer record: the question closes the message
               add_field(dmfp_pkg::KIND_QCLASS, word, an_count == 0);
               phase = (an_count == 0) ? ST_DONE : ST_ANAME;
            end
         end
         ST_ANAME: begin
            if (field_complete(b, 2, word)) begin
               add_field(dmfp_pkg::KIND_ANAME, word, 1'b0);
               phase = ST_ATYPE;
            end
         end
         ST_ATYPE: begin
            if (field_complete(b, 2, word)) begin
               add_field(dmfp_pkg::KIND_ATYPE, word, 1'b0);
               phase = ST_ACLASS;
            end
         end
         ST_ACLASS: begin
            if (field_complete(b, 2, word)) begin
               add_field(dmfp_pkg::KIND_ACLASS, word, 1'b0);
               phase = ST_TTL;
            end
         end
         ST_TTL: begin
            if (field_complete(b, 4, word)) begin
               add_field(dmfp_pkg::KIND_TTL, word, 1'b0);
               phase = ST_RDLEN;
            end
         end
         ST_RDLEN: begin
            if (field_complete(b, 2, word)) begin
               rdata_left = word[15:0];
               add_field(dmfp_pkg::KIND_RDLENGTH, word, rdata_left == 0);
               phase = (rdata_left == 0) ? ST_DONE : ST_RDATA;
            end
         end
         ST_RDATA: begin
            rdata_left = rdata_left - 16'd1;
            add_field(dmfp_pkg::KIND_RDATA, 32'(b), rdata_left == 0);
            if (rdata_left == 0)
               phase = ST_DONE;
         end
         default: phase = ST_DONE;  // trailing bytes are dropped
      endcase
      if (step_fields.size() > 0) begin
         last = step_fields.pop_back();
         last.run_end = 1'b1;
         step_fields.push_back(last);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // offer one byte, idling first at the phase's rate; the predictor runs on acceptance
   // and its results are queued unless the caller types them in itself
   task offer_byte(input logic [7:0] b, input logic som, input logic use_model);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push             <= 1'b1;
      req_data_byte        <= b;
      req_start_of_message <= som;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      bytes_sent++;
      parse_byte(b, som);
      if (use_model)
         foreach (step_fields[i])
            expected_fields.push_back(step_fields[i]);
   endtask

   // sender pauses until every queued result has come out
   task wait_drained();
      req_push <= 1'b0;
      do
         @(posedge clock);
      while (expected_fields.size() != 0);
   endtask

   // build one message with random content and send it, then a little trailing noise;
   // the first two messages pin down the no-answer and empty-rdata endings, broken
   // messages carry huge label lengths and get cut short so the next one restarts mid-parse
   task automatic send_random_message(input int unsigned msg_no);
      logic [7:0]  bytes_q[$];
      logic [15:0] an;
      logic [15:0] rdlen;
      int unsigned len;
      int unsigned cut;
      bit          broken;
      broken = (msg_no == 3) || (msg_no > 1 && $urandom_range(3) == 0);
      if (msg_no == 0)
         an = '0;
      else if (msg_no == 1 || $urandom_range(99) >= 40)
         an = 16'($urandom_range(1, 65535));
      else
         an = '0;
      repeat (6) bytes_q.push_back(8'($urandom));   // id, flags, qdcount
      bytes_q.push_back(an[15:8]);
      bytes_q.push_back(an[7:0]);
      repeat (4) bytes_q.push_back(8'($urandom));   // nscount, arcount
      repeat ($urandom_range(0, 2)) begin
         len = broken ? $urandom_range(64, 255) : $urandom_range(1, 3);
         bytes_q.push_back(8'(len));
         repeat (len) bytes_q.push_back(8'($urandom));
      end
      bytes_q.push_back(8'h00);
      repeat (4) bytes_q.push_back(8'($urandom));   // qtype, qclass
      if (an != 0) begin
         repeat (10) bytes_q.push_back(8'($urandom));  // name pointer, type, class, ttl
         if (broken)
            rdlen = 16'($urandom);
         else if (msg_no == 1 || $urandom_range(3) == 0)
            rdlen = '0;
         else
            rdlen = 16'($urandom_range(1, 4));
         bytes_q.push_back(rdlen[15:8]);
         bytes_q.push_back(rdlen[7:0]);
         if (!broken)
            repeat (rdlen) bytes_q.push_back(8'($urandom));
      end
      if (broken) begin
         cut = $urandom_range(1, (bytes_q.size() - 1 < 40) ? bytes_q.size() - 1 : 40);
         while (bytes_q.size() > cut)
            void'(bytes_q.pop_back());
      end
      foreach (bytes_q[i])
         offer_byte(bytes_q[i], i == 0, 1'b1);
      repeat ($urandom_range(0, 2))
         offer_byte(8'($urandom), 1'b0, 1'b1);
      messages_sent++;
   endtask

   // ---------------------------------------------------------------------------
   // receiver side
   // ---------------------------------------------------------------------------

   // pop at the phase's stall rate; a hold request freezes pop for a long stretch
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_pop      <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      dns_field_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rsp_message_done)
            messages_done++;
         if (expected_fields.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected result kind %0d value 0x%08h", $time,
                     rsp_field_kind, rsp_field_value);
         end else begin
            want = expected_fields.pop_front();
            results_checked++;
            if (rsp_field_kind !== want.kind) begin
               error_count++;
               $display("%0t ns: field_kind expected %0d, got %0d", $time,
                        want.kind, rsp_field_kind);
            end
            if (rsp_field_value !== want.value) begin
               error_count++;
               $display("%0t ns: field_value (kind %0d) expected 0x%08h, got 0x%08h",
                        $time, want.kind, want.value, rsp_field_value);
            end
            if (rsp_run_end !== want.run_end) begin
               error_count++;
               $display("%0t ns: run_end (kind %0d) expected %0b, got %0b", $time,
                        want.kind, want.run_end, rsp_run_end);
            end
            if (rsp_message_done !== want.done) begin
               error_count++;
               $display("%0t ns: message_done (kind %0d) expected %0b, got %0b", $time,
                        want.kind, want.done, rsp_message_done);
            end
         end
      end
   end

   // watchdog: too long with no item moving on either side means a hang
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t ns: watchdog timeout, %0d results still expected", $time,
               expected_fields.size());
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   initial begin
      int unsigned msg_no;
      msg_no = 0;
      restart_parse();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].data, directed_rows[i].som, !directed_rows[i].typed);
         if (directed_rows[i].typed)
            expected_fields.push_back('{directed_rows[i].kind, directed_rows[i].value,
                                        1'b1, directed_rows[i].done});
      end
      wait_drained();

      // random part: no idling, sender idle, receiver stalling, both
      for (int unsigned mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 47; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 47; end
            default: begin send_idle_pct = 37; pop_stall_pct = 37; end
         endcase
         send_random_message(msg_no);
         msg_no++;
         if (mode == 0) begin
            // receiver freezes while a whole message is offered, so req_full must rise
            hold_request <= 1'b1;
            send_random_message(msg_no);
            msg_no++;
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes (%0d directed, %0d random messages), %0d results checked,",
               bytes_sent, NUM_DIRECTED, messages_sent, results_checked);
      $display("%0d message ends seen, under four idling mixes and a long receiver hold",
               messages_done);
      if (expected_fields.size() != 0)
         $display("%0t ns: %0d expected results never arrived", $time,
                  expected_fields.size());
      if (error_count == 0 && expected_fields.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/dmfp_pkg.sv
rtl/core/dmfp_front.sv
rtl/core/dmfp_queue.sv
rtl/core/dmfp_back.sv
rtl/core/dns_message_field_parser_core.sv
test/tb_dns_message_field_parser_core.sv
